// ===== design/bta_pkg.sv =====
// Shared types, constants and helpers for the bridge traffic arbiter.
// Used by bta_core and bridge_traffic_arbiter; depends on nothing.
`timescale 1ns / 1ps

package bta_pkg;

    // Bridge tracker depth and derived widths
    localparam int BRIDGE_SLOTS = 16;
    localparam int SLOT_W       = (BRIDGE_SLOTS > 1) ? $clog2(BRIDGE_SLOTS) : 1;
    localparam int COUNT_W      = $clog2(BRIDGE_SLOTS + 1);

    // Fixed field widths
    localparam int QUEUE_W   = 8;
    localparam int TICK_W    = 8;
    localparam int GREEN_W   = 12;
    localparam int TPC_W     = 4;
    localparam int RED_W     = 4;
    localparam int TRANSIT_W = 8;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [QUEUE_W-1:0] QUEUE_MAX = {QUEUE_W{1'b1}};

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ARRIVE = 2'd1,
        FUNC_ENTER  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_CAR = 2'd0,
        CFG_ALL_RED_TICKS = 2'd1,
        CFG_TRANSIT_TICKS = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_idx_t;

    // Green owner codes
    typedef enum logic [1:0] {
        OWN_NONE  = 2'd0,
        OWN_NORTH = 2'd1,
        OWN_SOUTH = 2'd2,
        OWN_BAD   = 2'd3
    } owner_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_PHASE,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Configuration values handed to the core
    typedef struct packed {
        logic [TPC_W-1:0]     ticks_per_car;
        logic [RED_W-1:0]     all_red_ticks;
        logic [TRANSIT_W-1:0] transit_ticks;
    } cfg_t;

    // One result as seen on the output channel
    typedef struct packed {
        logic               north_green;
        logic               south_green;
        logic [QUEUE_W-1:0] north_count;
        logic [QUEUE_W-1:0] south_count;
        logic [COUNT_W-1:0] bridge_count;
        logic               entry_dropped;
    } result_t;

    // Advance a ring pointer with wrap at the tracker depth
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] ptr);
        logic [SLOT_W-1:0] nxt;
        if (ptr == SLOT_W'(BRIDGE_SLOTS - 1))
            nxt = '0;
        else
            nxt = ptr + 1'b1;
        return nxt;
    endfunction

endpackage

// ===== design/bta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the entry tick stamps of cars on the bridge.
`timescale 1ns / 1ps

module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bta_core.sv =====
// Sequencer and state of the bridge traffic arbiter: queues, bridge tracker,
// green and all-red phases. Uses bta_pkg and one bta_ram for entry stamps.
`timescale 1ns / 1ps

module bta_core
    import bta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic              side,
    input  cfg_t              cfg,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res
);

    state_t               state_reg, state_next;
    logic [QUEUE_W-1:0]   north_queue_reg, north_queue_next;
    logic [QUEUE_W-1:0]   south_queue_reg, south_queue_next;
    logic [COUNT_W-1:0]   on_bridge_reg, on_bridge_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [TICK_W-1:0]    tick_now_reg, tick_now_next;
    owner_t               owner_reg, owner_next;
    logic [GREEN_W-1:0]   green_left_reg, green_left_next;
    logic [RED_W-1:0]     red_left_reg, red_left_next;
    logic                 busy_reg, busy_next;
    logic                 north_last_reg, north_last_next;
    logic                 south_last_reg, south_last_next;
    logic                 dropped_reg, dropped_next;

    logic                 stamp_we;
    logic [TICK_W-1:0]    stamp_rdata;
    logic [TICK_W-1:0]    age;
    logic                 retire;
    logic [GREEN_W-1:0]   green_dec;
    logic [RED_W-1:0]     red_dec;
    logic                 open_north;
    logic                 open_south;
    logic [GREEN_W-1:0]   north_grant;
    logic [GREEN_W-1:0]   south_grant;
    logic                 accept;
    func_t                func_code;

    // Entry stamp ring; read address follows the next head so the oldest
    // stamp is ready in the cycle it is compared
    bta_ram #(
        .WIDTH (TICK_W),
        .DEPTH (BRIDGE_SLOTS)
    ) u_stamps (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (tail_reg),
        .wdata (tick_now_reg),
        .raddr (head_next),
        .rdata (stamp_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign func_code = func_t'(func);

    // Retire compare on the oldest car
    assign age    = tick_now_reg - stamp_rdata;
    assign retire = (on_bridge_reg != '0) && (age >= cfg.transit_ticks);

    // Phase countdowns
    assign green_dec = (green_left_reg != '0) ? green_left_reg - 1'b1 : green_left_reg;
    assign red_dec   = (red_left_reg != '0) ? red_left_reg - 1'b1 : red_left_reg;

    // Green grants
    assign north_grant = GREEN_W'(north_queue_reg) * GREEN_W'(cfg.ticks_per_car);
    assign south_grant = GREEN_W'(south_queue_reg) * GREEN_W'(cfg.ticks_per_car);

    // Opening choice
    always_comb
    begin
        open_north = 1'b0;
        open_south = 1'b0;
        if (on_bridge_reg == '0 && !busy_reg)
        begin
            priority if (north_queue_reg == '0 && south_queue_reg != '0)
                open_south = 1'b1;
            else if (south_queue_reg == '0 && north_queue_reg != '0)
                open_north = 1'b1;
            else if (!north_last_reg)
                open_north = 1'b1;
            else if (!south_last_reg)
                open_south = 1'b1;
            else if (north_queue_reg >= south_queue_reg && north_queue_reg != '0)
                open_north = 1'b1;
            else if (south_queue_reg >= north_queue_reg && south_queue_reg != '0)
                open_south = 1'b1;
        end
    end

    // Hold state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            north_queue_reg <= '0;
            south_queue_reg <= '0;
            on_bridge_reg   <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            tick_now_reg    <= '0;
            owner_reg       <= OWN_NONE;
            green_left_reg  <= '0;
            red_left_reg    <= '0;
            busy_reg        <= 1'b0;
            north_last_reg  <= 1'b1;
            south_last_reg  <= 1'b1;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            north_queue_reg <= north_queue_next;
            south_queue_reg <= south_queue_next;
            on_bridge_reg   <= on_bridge_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            tick_now_reg    <= tick_now_next;
            owner_reg       <= owner_next;
            green_left_reg  <= green_left_next;
            red_left_reg    <= red_left_next;
            busy_reg        <= busy_next;
            north_last_reg  <= north_last_next;
            south_last_reg  <= south_last_next;
            dropped_reg     <= dropped_next;
        end
    end

    // Sequence one request
    always_comb
    begin
        state_next       = state_reg;
        north_queue_next = north_queue_reg;
        south_queue_next = south_queue_reg;
        on_bridge_next   = on_bridge_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        tick_now_next    = tick_now_reg;
        owner_next       = owner_reg;
        green_left_next  = green_left_reg;
        red_left_next    = red_left_reg;
        busy_next        = busy_reg;
        north_last_next  = north_last_reg;
        south_last_next  = south_last_reg;
        dropped_next     = dropped_reg;
        stamp_we         = 1'b0;
        res_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dropped_next = 1'b0;
                    state_next   = ST_DONE;
                    unique case (func_code)
                        FUNC_TICK:
                        begin
                            tick_now_next = tick_now_reg + 1'b1;
                            state_next    = ST_RETIRE;
                        end
                        FUNC_ARRIVE:
                        begin
                            if (!side && north_queue_reg != QUEUE_MAX)
                                north_queue_next = north_queue_reg + 1'b1;
                            if (side && south_queue_reg != QUEUE_MAX)
                                south_queue_next = south_queue_reg + 1'b1;
                        end
                        FUNC_ENTER:
                        begin
                            if (on_bridge_reg >= COUNT_W'(BRIDGE_SLOTS))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                stamp_we       = 1'b1;
                                tail_next      = slot_inc(tail_reg);
                                on_bridge_next = on_bridge_reg + 1'b1;
                                if (!side && north_queue_reg != '0)
                                    north_queue_next = north_queue_reg - 1'b1;
                                if (side && south_queue_reg != '0)
                                    south_queue_next = south_queue_reg - 1'b1;
                            end
                        end
                        FUNC_NOP:
                        begin
                            dropped_next = 1'b0;
                        end
                    endcase
                end
            end

            // Drop one expired car per cycle, oldest first
            ST_RETIRE:
            begin
                if (retire)
                begin
                    head_next      = slot_inc(head_reg);
                    on_bridge_next = on_bridge_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_PHASE;
                end
            end

            // Advance green or all-red countdown
            ST_PHASE:
            begin
                if (owner_reg != OWN_NONE)
                begin
                    green_left_next = green_dec;
                    if (green_dec == '0)
                    begin
                        owner_next    = OWN_NONE;
                        red_left_next = cfg.all_red_ticks;
                        if (cfg.all_red_ticks == '0)
                            busy_next = 1'b0;
                    end
                end
                else if (busy_reg)
                begin
                    red_left_next = red_dec;
                    if (red_dec == '0)
                        busy_next = 1'b0;
                end
                state_next = ST_DECIDE;
            end

            // Open a side when the bridge is empty and free
            ST_DECIDE:
            begin
                if (open_north || open_south)
                begin
                    owner_next      = open_north ? OWN_NORTH : OWN_SOUTH;
                    green_left_next = open_north ? north_grant : south_grant;
                    busy_next       = 1'b1;
                    north_last_next = open_north;
                    south_last_next = open_south;
                end
                state_next = ST_DONE;
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result view of the state after the request
    assign res.north_green   = (owner_reg == OWN_NORTH);
    assign res.south_green   = (owner_reg == OWN_SOUTH);
    assign res.north_count   = north_queue_reg;
    assign res.south_count   = south_queue_reg;
    assign res.bridge_count  = on_bridge_reg;
    assign res.entry_dropped = dropped_reg;

endmodule

// ===== design/bridge_traffic_arbiter.sv =====
// Top level of the bridge traffic arbiter: configuration registers, output
// register and the sequencing core. Uses bta_pkg and bta_core.
`timescale 1ns / 1ps

// Controls the two lights of a one-lane bridge from a stream of requests:
// half-second ticks, car arrivals at either end and car entries onto the
// bridge. Each accepted request returns one result with both lights, both
// queue counts, the cars on the bridge and a flag for an entry dropped
// because the bridge tracker was full. Arrivals, entries and no-op requests
// go from accept straight to the result; a tick first passes through the
// retire, phase and decide states and stays in retire while cars leave the
// bridge on that tick, because the oldest entry stamp is read from the stamp
// RAM and compared against the transit time one car per cycle. A result that
// waits in a full output register adds its stall cycles. The block takes the
// next request as soon as its result sits in the output register.
// Configuration writes are taken every cycle and should be made only while
// no request is in progress.

module bridge_traffic_arbiter
    import bta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic                 side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 north_green,
    output logic                 south_green,
    output logic [QUEUE_W-1:0]   north_count,
    output logic [QUEUE_W-1:0]   south_count,
    output logic [COUNT_W-1:0]   bridge_count,
    output logic                 entry_dropped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TRANSIT_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    result_t result_reg;
    result_t core_res;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    res_load;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICKS_PER_CAR: cfg_next.ticks_per_car = cfg_data[TPC_W-1:0];
                CFG_ALL_RED_TICKS: cfg_next.all_red_ticks = cfg_data[RED_W-1:0];
                CFG_TRANSIT_TICKS: cfg_next.transit_ticks = cfg_data;
                CFG_UNUSED:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_car <= TPC_W'(2);
            cfg_reg.all_red_ticks <= RED_W'(2);
            cfg_reg.transit_ticks <= TRANSIT_W'(10);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bta_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .side     (side),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .res_load (res_load),
        .res      (core_res)
    );

    // Output register: free when empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= core_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign north_green   = result_reg.north_green;
    assign south_green   = result_reg.south_green;
    assign north_count   = result_reg.north_count;
    assign south_count   = result_reg.south_count;
    assign bridge_count  = result_reg.bridge_count;
    assign entry_dropped = result_reg.entry_dropped;

endmodule
